>>> rtl/cmrf_pkg.sv
`timescale 1ns / 1ps

package cmrf_pkg;

    localparam int RING_DEPTH_DEF  = 64;
    localparam int DRAIN_BATCH_DEF = 16;

    localparam int MARKER_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    // func codes
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PUSH_ACK = 2'd0;
    localparam logic [1:0] KIND_DRAINED  = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    // push status codes
    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_BYPASSED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_GRAY  = 8'd1;

    typedef struct packed {
        logic load;   // latch the accepted word
        logic push;   // store / acknowledge a marker
        logic rd;     // pop one marker from the ring
        logic empty;  // report an empty drain
    } t_cmd;

    typedef struct packed {
        logic fill_zero;
        logic drain_last;
    } t_stat;

endpackage

>>> rtl/cmrf_ram.sv
`timescale 1ns / 1ps

module cmrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cmrf_ctrl.sv
`timescale 1ns / 1ps

module cmrf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  cmrf_pkg::t_stat i_stat,
    output cmrf_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import cmrf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PUSH  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_PUSH) ? S_PUSH : S_DRAIN;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_IDLE;
            end
            S_DRAIN: begin
                if (i_stat.fill_zero) begin
                    o_cmd.empty = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    if (i_stat.drain_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/cmrf_dp.sv
`timescale 1ns / 1ps

module cmrf_dp #(
    parameter int RING_DEPTH  = cmrf_pkg::RING_DEPTH_DEF,
    parameter int DRAIN_BATCH = cmrf_pkg::DRAIN_BATCH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cmrf_pkg::t_cmd                    i_cmd,
    output cmrf_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_valid,
    input  logic [cmrf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cmrf_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic [cmrf_pkg::MARKER_W-1:0]     i_marker_in,
    output logic                              o_res_strobe,
    output logic [1:0]                        o_kind,
    output logic [cmrf_pkg::MARKER_W-1:0]     o_marker_out,
    output logic [1:0]                        o_push_status,
    output logic                              o_above_threshold,
    output logic [$clog2(RING_DEPTH+1)-1:0]   o_fill_after,
    output logic                              o_last
);
    import cmrf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int CW = $clog2(DRAIN_BATCH + 1);
    localparam int WAKE_LEVEL = RING_DEPTH / 2;

    logic                r_fast;
    logic                r_inv;
    logic [AW-1:0]       r_rd_ptr;
    logic [AW-1:0]       r_wr_ptr;
    logic [FW-1:0]       r_fill;
    logic [FW-1:0]       n_fill;
    logic [CW-1:0]       r_cnt;
    logic [MARKER_W-1:0] r_marker;

    logic                r_strobe;
    logic [1:0]          r_kind;
    logic [1:0]          r_status;
    logic                r_above;
    logic [FW-1:0]       r_res_fill;
    logic                r_last;

    logic                bypass;
    logic                full;
    logic                do_store;
    logic [MARKER_W-1:0] ram_q;

    assign bypass   = r_fast | r_inv;
    assign full     = (r_fill == FW'(RING_DEPTH));
    assign do_store = i_cmd.push & ~bypass & ~full;

    assign o_stat.fill_zero  = (r_fill == '0);
    assign o_stat.drain_last = (r_fill == FW'(1)) || (r_cnt == CW'(DRAIN_BATCH - 1));

    always_comb begin
        n_fill = r_fill;
        if (do_store) begin
            n_fill = r_fill + FW'(1);
        end else if (i_cmd.rd) begin
            n_fill = r_fill - FW'(1);
        end
    end

    cmrf_ram #(
        .WIDTH (MARKER_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_re    (i_cmd.rd),
        .i_addr  (i_cmd.rd ? r_rd_ptr : r_wr_ptr),
        .i_wdata (r_marker),
        .o_rdata (ram_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast   <= 1'b0;
            r_inv    <= 1'b0;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_FAST_MODE)) begin
                r_fast <= i_cfg_data[0];
            end
            if (i_cfg_valid && (i_cfg_index == CFG_INV_GRAY)) begin
                r_inv <= i_cfg_data[0];
            end
            if (do_store) begin
                r_wr_ptr <= (r_wr_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_cmd.rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.rd) begin
                r_cnt <= r_cnt + CW'(1);
            end
            r_fill   <= n_fill;
            r_strobe <= i_cmd.push | i_cmd.rd | i_cmd.empty;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_marker <= i_marker_in;
        end
        if (i_cmd.push) begin
            r_kind <= KIND_PUSH_ACK;
        end else if (i_cmd.rd) begin
            r_kind <= KIND_DRAINED;
        end else begin
            r_kind <= KIND_EMPTY;
        end
        if (i_cmd.push && bypass) begin
            r_status <= ST_BYPASSED;
        end else if (i_cmd.push && full) begin
            r_status <= ST_DROPPED;
        end else begin
            r_status <= ST_STORED;
        end
        // no wake while bypassed
        r_above    <= i_cmd.push & ~bypass & (n_fill > FW'(WAKE_LEVEL));
        r_res_fill <= n_fill;
        r_last     <= i_cmd.push | i_cmd.empty | (i_cmd.rd & o_stat.drain_last);
    end

    assign o_res_strobe      = r_strobe;
    assign o_kind            = r_kind;
    assign o_marker_out      = (r_kind == KIND_DRAINED) ? ram_q : '0;
    assign o_push_status     = r_status;
    assign o_above_threshold = r_above;
    assign o_fill_after      = r_res_fill;
    assign o_last            = r_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.rd && (i_cmd.push || i_cmd.empty)))
        else $error("ring read clashes with push or empty report");

    a_drain_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_kind == KIND_DRAINED) && (r_res_fill == '0)) |-> r_last)
        else $error("ring emptied without last flag");

    a_rd_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |=> (r_fill == $past(r_fill) - FW'(1)))
        else $error("ring read did not consume one word");
`endif

endmodule

>>> rtl/completed_marker_ring_fifo_unit.sv
`timescale 1ns / 1ps
// Push: the PUSH state and then the result register lie between accept and strobe; busy is
// high for a single cycle, and a new push is taken only once busy falls.
// Drain of n markers (n = min(fill, DRAIN_BATCH)): words come from the registered read of the
// single-port ring RAM, one word per cycle; a new item is taken only after the last word.
// Empty drain: one word, with no ring read. Receiver cannot stall; config ready always.
// Reset (sync, active low): pointers, fill and mode registers cleared; ring contents undefined.
module completed_marker_ring_fifo_unit #(
    parameter int RING_DEPTH  = cmrf_pkg::RING_DEPTH_DEF,
    parameter int DRAIN_BATCH = cmrf_pkg::DRAIN_BATCH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [cmrf_pkg::MARKER_W-1:0]   i_marker_in,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cmrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cmrf_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output logic                            o_res_strobe,
    output logic [1:0]                      o_kind,
    output logic [cmrf_pkg::MARKER_W-1:0]   o_marker_out,
    output logic [1:0]                      o_push_status,
    output logic                            o_above_threshold,
    output logic [$clog2(RING_DEPTH+1)-1:0] o_fill_after,
    output logic                            o_last
);
    import cmrf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cmrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cmrf_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .DRAIN_BATCH (DRAIN_BATCH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_valid       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_marker_in       (i_marker_in),
        .o_res_strobe      (o_res_strobe),
        .o_kind            (o_kind),
        .o_marker_out      (o_marker_out),
        .o_push_status     (o_push_status),
        .o_above_threshold (o_above_threshold),
        .o_fill_after      (o_fill_after),
        .o_last            (o_last)
    );

endmodule

>>> tb/cmrf_checker.sv
`timescale 1ns / 1ps

module cmrf_checker #(
    parameter int RING_DEPTH  = cmrf_pkg::RING_DEPTH_DEF,
    parameter int DRAIN_BATCH = cmrf_pkg::DRAIN_BATCH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_func,
    input  logic [cmrf_pkg::MARKER_W-1:0]   i_marker_in,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [cmrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cmrf_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            o_res_strobe,
    input  logic [1:0]                      o_kind,
    input  logic [cmrf_pkg::MARKER_W-1:0]   o_marker_out,
    input  logic [1:0]                      o_push_status,
    input  logic                            o_above_threshold,
    input  logic [$clog2(RING_DEPTH+1)-1:0] o_fill_after,
    input  logic                            o_last,
    output int                              fail_count,
    output int                              words_pending
);
    import cmrf_pkg::*;

    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int PTR_W  = $clog2(RING_DEPTH);

    typedef struct packed {
        logic [1:0]          kind;
        logic [MARKER_W-1:0] marker;
        logic [1:0]          status;
        logic                above;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } t_marker_word;

    t_marker_word        expected_words[$];
    logic [MARKER_W-1:0] ring_copy[RING_DEPTH];
    logic [PTR_W-1:0]    rd_ptr = '0;
    logic [PTR_W-1:0]    wr_ptr = '0;
    int                  fill_level = 0;
    logic                fast_mode_r = 1'b0;
    logic                inv_gray_r = 1'b0;
    int                  errors = 0;

    initial begin
        fail_count = 0;
        words_pending = 0;
    end

    task automatic predict_fifo_words(input logic func, input logic [MARKER_W-1:0] marker);
        t_marker_word w;
        int n;
        w = '0;
        w.last = 1'b1;
        if (func == FUNC_PUSH) begin
            w.kind = KIND_PUSH_ACK;
            if (fast_mode_r || inv_gray_r) begin
                // bypassed: no store, no wake
                w.status = ST_BYPASSED;
            end else begin
                if (fill_level < RING_DEPTH) begin
                    ring_copy[wr_ptr] = marker;
                    wr_ptr = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
                    fill_level++;
                    w.status = ST_STORED;
                end else begin
                    w.status = ST_DROPPED;
                end
                w.above = (fill_level > RING_DEPTH / 2);
            end
            w.fill = FILL_W'(fill_level);
            expected_words.push_back(w);
        end else if (fill_level == 0) begin
            w.kind = KIND_EMPTY;
            expected_words.push_back(w);
        end else begin
            n = (fill_level < DRAIN_BATCH) ? fill_level : DRAIN_BATCH;
            for (int i = 0; i < n; i++) begin
                w.kind   = KIND_DRAINED;
                w.marker = ring_copy[rd_ptr];
                rd_ptr = (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
                fill_level--;
                w.fill = FILL_W'(fill_level);
                w.last = (i == n - 1);
                expected_words.push_back(w);
            end
        end
    endtask

    task automatic check_word();
        t_marker_word got;
        t_marker_word want;
        got.kind   = o_kind;
        got.marker = o_marker_out;
        got.status = o_push_status;
        got.above  = o_above_threshold;
        got.fill   = o_fill_after;
        got.last   = o_last;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display({"unexpected word: kind=%0d marker=%h status=%0d above=%0d",
                          " fill=%0d last=%0d"},
                         got.kind, got.marker, got.status, got.above, got.fill, got.last);
        end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind || got.marker !== want.marker ||
                got.status !== want.status || got.above !== want.above ||
                got.fill !== want.fill || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("word mismatch at %0t", $realtime);
                    $display("  exp kind=%0d marker=%h status=%0d above=%0d fill=%0d last=%0d",
                             want.kind, want.marker, want.status, want.above, want.fill,
                             want.last);
                    $display("  got kind=%0d marker=%h status=%0d above=%0d fill=%0d last=%0d",
                             got.kind, got.marker, got.status, got.above, got.fill, got.last);
                end
            end
        end
    endtask

    // results always come from words accepted at earlier edges, so check first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            rd_ptr      = '0;
            wr_ptr      = '0;
            fill_level  = 0;
            fast_mode_r = 1'b0;
            inv_gray_r  = 1'b0;
        end else begin
            if (o_res_strobe)
                check_word();
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FAST_MODE)
                    fast_mode_r = i_cfg_data[0];
                else if (i_cfg_index == CFG_INV_GRAY)
                    inv_gray_r = i_cfg_data[0];
            end
            if (start && !busy)
                predict_fifo_words(i_func, i_marker_in);
        end
        words_pending <= expected_words.size();
        fail_count    <= errors;
    end

endmodule

>>> tb/tb_completed_marker_ring_fifo_unit.sv
`timescale 1ns / 1ps

module tb_completed_marker_ring_fifo_unit;
    import cmrf_pkg::*;

    localparam int RING_DEPTH  = RING_DEPTH_DEF;
    localparam int DRAIN_BATCH = DRAIN_BATCH_DEF;
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_func;
    logic [MARKER_W-1:0]  i_marker_in;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_res_strobe;
    logic [1:0]           o_kind;
    logic [MARKER_W-1:0]  o_marker_out;
    logic [1:0]           o_push_status;
    logic                 o_above_threshold;
    logic [FILL_W-1:0]    o_fill_after;
    logic                 o_last;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;

    completed_marker_ring_fifo_unit #(
        .RING_DEPTH  (RING_DEPTH),
        .DRAIN_BATCH (DRAIN_BATCH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_marker_in       (i_marker_in),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_res_strobe      (o_res_strobe),
        .o_kind            (o_kind),
        .o_marker_out      (o_marker_out),
        .o_push_status     (o_push_status),
        .o_above_threshold (o_above_threshold),
        .o_fill_after      (o_fill_after),
        .o_last            (o_last)
    );

    cmrf_checker #(
        .RING_DEPTH  (RING_DEPTH),
        .DRAIN_BATCH (DRAIN_BATCH)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_marker_in       (i_marker_in),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_res_strobe      (o_res_strobe),
        .o_kind            (o_kind),
        .o_marker_out      (o_marker_out),
        .o_push_status     (o_push_status),
        .o_above_threshold (o_above_threshold),
        .o_fill_after      (o_fill_after),
        .o_last            (o_last),
        .fail_count        (fail_count),
        .words_pending     (words_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // start stays high across back-to-back words; only the caller lowers it
    task automatic send_word(input logic func, input logic [MARKER_W-1:0] marker);
        start       <= 1'b1;
        i_func      <= func;
        i_marker_in <= marker;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pace();
        if (gaps_on && burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // upper data bits are junk on purpose; only bit 0 counts
    task automatic set_modes(input logic fast, input logic inv);
        logic [CFG_DAT_W-1:0] d;
        if ($urandom_range(0, 1) == 1) begin
            d = $urandom();
            write_reg(CFG_IDX_W'($urandom_range(CFG_INV_GRAY + 1, (1 << CFG_IDX_W) - 1)), d);
        end
        d = $urandom();
        d[0] = fast;
        write_reg(CFG_FAST_MODE, d);
        d = $urandom();
        d[0] = inv;
        write_reg(CFG_INV_GRAY, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic fast, input logic inv, input int push_pct,
                             input int count, input bit gaps);
        settle();
        set_modes(fast, inv);
        gaps_on    = gaps;
        burst_left = 0;
        repeat (count) begin
            pace();
            if ($urandom_range(0, 99) < push_pct)
                send_word(FUNC_PUSH, $urandom());
            else
                send_word(FUNC_DRAIN, $urandom());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_PUSH;
        i_marker_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FAST_MODE;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty drain, marker extremes, short drain, exact batch drain
        send_word(FUNC_DRAIN, '0);
        send_word(FUNC_PUSH, '0);
        send_word(FUNC_PUSH, '1);
        send_word(FUNC_PUSH, 32'hA5A5_5A5A);
        send_word(FUNC_PUSH, 32'h5A5A_A5A5);
        send_word(FUNC_DRAIN, $urandom());
        repeat (DRAIN_BATCH) send_word(FUNC_PUSH, $urandom());
        send_word(FUNC_DRAIN, '1);

        // bypass in each mode; drain still works while bypassed
        settle();
        set_modes(1'b1, 1'b0);
        send_word(FUNC_PUSH, $urandom());
        settle();
        set_modes(1'b0, 1'b1);
        send_word(FUNC_PUSH, $urandom());
        send_word(FUNC_DRAIN, $urandom());

        // fill to overflow, bypass at full, drain down, then mixed traffic
        run_phase(1'b0, 1'b0, 98, 90, 1'b0);
        run_phase(1'b1, 1'b0, 60, 25, 1'b1);
        run_phase(1'b0, 1'b1, 60, 25, 1'b1);
        run_phase(1'b1, 1'b1, 50, 30, 1'b1);
        run_phase(1'b0, 1'b0, 30, 40, 1'b1);
        run_phase(1'b0, 1'b0, 94, 80, 1'b1);
        run_phase(1'b0, 1'b0, 98, 60, 1'b0);

        settle();
        if (fail_count == 0 && words_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cmrf_pkg.sv
rtl/cmrf_ram.sv
rtl/cmrf_ctrl.sv
rtl/cmrf_dp.sv
rtl/completed_marker_ring_fifo_unit.sv
tb/cmrf_checker.sv
tb/tb_completed_marker_ring_fifo_unit.sv
